/* hw/rtl/gn2_pkg.sv */
// gn2_pkg: shared types and constants of the 2D gradient noise sampler.
// Used by every module of the block except gn2_ram; depends on nothing.
package gn2_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_TPL   = 128;
	localparam int TPL_AW    = 7;
	localparam int GRID_W    = 11;
	localparam int MAX_GRID  = 1024;
	localparam int MIN_GRID  = 2;

	localparam logic [1:0] FN_SAMPLE = 2'd0;
	localparam logic [1:0] FN_TPL    = 2'd1;
	localparam logic [1:0] FN_PERM   = 2'd2;

	localparam logic [2:0] REG_COLS = 3'd0;
	localparam logic [2:0] REG_ROWS = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic [16:0]        coord_u;
		logic [16:0]        coord_v;
		logic [6:0]         table_index;
		logic signed [15:0] grad_x;
		logic signed [15:0] grad_y;
		logic [6:0]         perm_entry;
	} gn2_req_t;

	typedef struct packed {
		logic signed [15:0] noise_value;
		logic [15:0]        noise_norm;
	} gn2_rsp_t;

	function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] g);
		if (g < GRID_W'(MIN_GRID))
			return GRID_W'(MIN_GRID);
		if (g > GRID_W'(MAX_GRID))
			return GRID_W'(MAX_GRID);
		return g;
	endfunction

endpackage

/* hw/rtl/gn2_ram.sv */
// gn2_ram: generic RAM, one write port and two registered read ports.
// Standalone; no package needed.
module gn2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

/* hw/rtl/gn2_perm_lut.sv */
// gn2_perm_lut: permutation table copy with per-entry valid bits; unwritten
// entries read as their own index. Depends on gn2_pkg and gn2_ram.
module gn2_perm_lut
	import gn2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [TPL_AW-1:0] waddr,
	input  logic [TPL_AW-1:0] wdata,
	input  logic              re,
	input  logic [TPL_AW-1:0] raddr0,
	input  logic [TPL_AW-1:0] raddr1,
	output logic [TPL_AW-1:0] rdata0,
	output logic [TPL_AW-1:0] rdata1
);

	logic [NUM_TPL-1:0] vld_q;
	logic               hit0_q, hit1_q;
	logic [TPL_AW-1:0]  addr0_q, addr1_q;
	logic [TPL_AW-1:0]  ram0, ram1;

	gn2_ram #(.WIDTH(TPL_AW), .DEPTH(NUM_TPL)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .re(re),
		.raddr0(raddr0), .raddr1(raddr1), .rdata0(ram0), .rdata1(ram1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			hit0_q <= 1'b0;
			hit1_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re) begin
				hit0_q <= vld_q[raddr0];
				hit1_q <= vld_q[raddr1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			addr0_q <= raddr0;
			addr1_q <= raddr1;
		end
	end

	assign rdata0 = hit0_q ? ram0 : addr0_q;
	assign rdata1 = hit1_q ? ram1 : addr1_q;

endmodule

/* hw/rtl/gradient_noise_2d_sampler_core.sv */
// gradient_noise_2d_sampler_core: top level, 8-stage gradient noise pipeline.
// Depends on gn2_pkg, gn2_ram, gn2_perm_lut.
//
//   channel | signals                          | beat
//   req     | req_valid, req_ready, req        | sample or table write
//   rsp     | rsp_valid, rsp_ready, rsp        | noise sample
//   cfg     | psel, penable, pwrite, paddr ... | grid_cols / grid_rows
//
// One beat per cycle unless rsp stalls; samples pass s1..s7, then rsp_q.
// The whole pipeline holds while a result waits on rsp.
// Table writes land in each table copy at the stage that reads it.
// Reset clears valid bits; the permutation reads as identity until written.
module gradient_noise_2d_sampler_core
	import gn2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  gn2_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output gn2_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	function automatic logic signed [19:0] dot_q15(
		input logic [31:0] tpl, input logic signed [17:0] dx,
		input logic signed [17:0] dy);
		logic signed [34:0] d;
		d = 35'($signed(tpl[31:16]) * dx) + 35'($signed(tpl[15:0]) * dy);
		d = d + 35'sd16384;
		return 20'(d >>> 15);
	endfunction

	function automatic logic signed [21:0] blend(
		input logic signed [21:0] a, input logic signed [21:0] b,
		input logic [16:0] s);
		logic signed [22:0] diff;
		logic signed [40:0] prod;
		diff = 23'(b) - 23'(a);
		prod = 41'(diff * $signed({1'b0, s}));
		prod = prod + 41'sd32768;
		return a + 22'(prod >>> 16);
	endfunction

	// configuration
	logic [GRID_W-1:0] cols_q, rows_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROWS[2]) ? {21'b0, rows_q} : {21'b0, cols_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= GRID_W'(64);
			rows_q <= GRID_W'(64);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ROWS[2])
				rows_q <= pwdata[GRID_W-1:0];
			else
				cols_q <= pwdata[GRID_W-1:0];
		end
	end

	logic adv;
	logic rsp_valid_q;
	gn2_rsp_t rsp_q;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	gn2_req_t d_s1, d_s2, d_s3, d_s4;
	logic [1:0] func_s5, func_s6, func_s7;
	logic [GRID_W-1:0] cols_s1, rows_s1, cols_s2, rows_s2;
	logic [27:0] px_s2, py_s2;
	logic [GRID_W-1:0] col0_s3, col1_s3;
	logic [15:0] fx_s3, fy_s3, t2x_s3, t2y_s3;
	logic [15:0] fx_s4, fy_s4, t3x_s4, t3y_s4;
	logic [20:0] px_p_s4, py_p_s4;
	logic [16:0] su_s5, sv_s5, su_s6, sv_s6, sv_s7;
	logic [15:0] fx_s5, fy_s5;
	logic signed [19:0] n0_s6, n1_s6, n2_s6, n3_s6;
	logic signed [21:0] top_s7, bot_s7;

	// stage 2 -> 3 logic
	logic [11:0] c0, r0;
	logic [GRID_W-1:0] col0, col1, row0, row1;
	logic [31:0] fxx, fyy;
	logic [TPL_AW-1:0] a0, a1;

	always_comb begin
		c0   = px_s2[27:16];
		r0   = py_s2[27:16];
		col0 = (c0 >= {1'b0, cols_s2}) ? 11'(c0 - {1'b0, cols_s2}) : c0[10:0];
		row0 = (r0 >= {1'b0, rows_s2}) ? 11'(r0 - {1'b0, rows_s2}) : r0[10:0];
		col1 = (col0 + 11'd1 == cols_s2) ? '0 : col0 + 11'd1;
		row1 = (row0 + 11'd1 == rows_s2) ? '0 : row0 + 11'd1;
		fxx  = px_s2[15:0] * px_s2[15:0];
		fyy  = py_s2[15:0] * py_s2[15:0];
	end

	gn2_perm_lut u_perm_row (
		.clk(clk), .arst_n(arst_n),
		.we(adv && v_s2 && d_s2.func == FN_PERM),
		.waddr(d_s2.table_index), .wdata(d_s2.perm_entry),
		.re(adv), .raddr0(row0[TPL_AW-1:0]), .raddr1(row1[TPL_AW-1:0]),
		.rdata0(a0), .rdata1(a1)
	);

	// stage 3 -> 4 logic
	logic [31:0] t3x_full, t3y_full;
	logic [20:0] posx, negx, posy, negy;
	logic [TPL_AW-1:0] g00, g01, g10, g11;

	always_comb begin
		t3x_full = t2x_s3 * fx_s3;
		t3y_full = t2y_s3 * fy_s3;
		posx = 21'd655360 + 21'(t2x_s3) * 21'd6;
		negx = 21'(fx_s3) * 21'd15;
		posy = 21'd655360 + 21'(t2y_s3) * 21'd6;
		negy = 21'(fy_s3) * 21'd15;
	end

	gn2_perm_lut u_perm_top (
		.clk(clk), .arst_n(arst_n),
		.we(adv && v_s3 && d_s3.func == FN_PERM),
		.waddr(d_s3.table_index), .wdata(d_s3.perm_entry),
		.re(adv), .raddr0(a0 + col0_s3[TPL_AW-1:0]), .raddr1(a0 + col1_s3[TPL_AW-1:0]),
		.rdata0(g00), .rdata1(g01)
	);

	gn2_perm_lut u_perm_bot (
		.clk(clk), .arst_n(arst_n),
		.we(adv && v_s3 && d_s3.func == FN_PERM),
		.waddr(d_s3.table_index), .wdata(d_s3.perm_entry),
		.re(adv), .raddr0(a1 + col0_s3[TPL_AW-1:0]), .raddr1(a1 + col1_s3[TPL_AW-1:0]),
		.rdata0(g10), .rdata1(g11)
	);

	// stage 4 -> 5 logic
	logic [36:0] sux_full, svx_full;
	logic [31:0] tpl00, tpl01, tpl10, tpl11;
	logic tpl_we;

	assign sux_full = 37'(t3x_s4) * 37'(px_p_s4);
	assign svx_full = 37'(t3y_s4) * 37'(py_p_s4);
	assign tpl_we   = adv && v_s4 && d_s4.func == FN_TPL;

	gn2_ram #(.WIDTH(32), .DEPTH(NUM_TPL)) u_tpl_top (
		.clk(clk), .we(tpl_we), .waddr(d_s4.table_index),
		.wdata({d_s4.grad_x, d_s4.grad_y}), .re(adv),
		.raddr0(g00), .raddr1(g01), .rdata0(tpl00), .rdata1(tpl01)
	);

	gn2_ram #(.WIDTH(32), .DEPTH(NUM_TPL)) u_tpl_bot (
		.clk(clk), .we(tpl_we), .waddr(d_s4.table_index),
		.wdata({d_s4.grad_x, d_s4.grad_y}), .re(adv),
		.raddr0(g10), .raddr1(g11), .rdata0(tpl10), .rdata1(tpl11)
	);

	// stage 5 -> 6 logic
	logic signed [17:0] dx0, dx1, dy0, dy1;

	always_comb begin
		dx0 = $signed({2'b0, fx_s5});
		dy0 = $signed({2'b0, fy_s5});
		dx1 = dx0 - 18'sd65536;
		dy1 = dy0 - 18'sd65536;
	end

	// output logic
	logic signed [21:0] val;
	logic signed [15:0] sat;
	logic [15:0] norm;

	always_comb begin
		val = blend(top_s7, bot_s7, sv_s7);
		if (val > 22'sd32767)
			sat = 16'sh7FFF;
		else if (val < -22'sd32768)
			sat = 16'sh8000;
		else
			sat = val[15:0];
		if (val > 22'sd32767)
			norm = 16'hFFFF;
		else if (val < -22'sd32768)
			norm = 16'h0000;
		else
			norm = val[15:0] ^ 16'h8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			rsp_valid_q <= v_s7 && func_s7 == FN_SAMPLE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1    <= req;
			cols_s1 <= clamp_grid(cols_q);
			rows_s1 <= clamp_grid(rows_q);

			d_s2    <= d_s1;
			cols_s2 <= cols_s1;
			rows_s2 <= rows_s1;
			px_s2   <= 28'(d_s1.coord_u) * 28'(cols_s1);
			py_s2   <= 28'(d_s1.coord_v) * 28'(rows_s1);

			d_s3    <= d_s2;
			col0_s3 <= col0;
			col1_s3 <= col1;
			fx_s3   <= px_s2[15:0];
			fy_s3   <= py_s2[15:0];
			t2x_s3  <= fxx[31:16];
			t2y_s3  <= fyy[31:16];

			d_s4    <= d_s3;
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			t3x_s4  <= t3x_full[31:16];
			t3y_s4  <= t3y_full[31:16];
			px_p_s4 <= (posx >= negx) ? posx - negx : '0;
			py_p_s4 <= (posy >= negy) ? posy - negy : '0;

			func_s5 <= d_s4.func;
			fx_s5   <= fx_s4;
			fy_s5   <= fy_s4;
			su_s5   <= sux_full[32:16];
			sv_s5   <= svx_full[32:16];

			func_s6 <= func_s5;
			su_s6   <= su_s5;
			sv_s6   <= sv_s5;
			n0_s6   <= dot_q15(tpl00, dx0, dy0);
			n1_s6   <= dot_q15(tpl01, dx1, dy0);
			n2_s6   <= dot_q15(tpl10, dx0, dy1);
			n3_s6   <= dot_q15(tpl11, dx1, dy1);

			func_s7 <= func_s6;
			sv_s7   <= sv_s6;
			top_s7  <= blend(22'(n0_s6), 22'(n1_s6), su_s6);
			bot_s7  <= blend(22'(n2_s6), 22'(n3_s6), su_s6);

			rsp_q.noise_value <= sat;
			rsp_q.noise_norm  <= norm;
		end
	end

	a_norm_tracks_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.noise_norm == (rsp.noise_value ^ 16'h8000))
		else $error("noise_norm disagrees with noise_value");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s7 && func_s7 != FN_SAMPLE |=> !rsp_valid)
		else $error("table write produced a result beat");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s7) && $stable(top_s7))
		else $error("pipeline moved during stall");

endmodule

/* verif/gradient_noise_2d_sampler_core_tb.sv */
// Testbench for gradient_noise_2d_sampler_core: random table loads, grid
// settings and noise samples are checked against a fixed-point noise predictor.
// Depends on gn2_pkg and the sampler RTL.
module gradient_noise_2d_sampler_core_tb;
	import gn2_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class noise_scoreboard;
		int unsigned grid_c, grid_r;
		logic signed [15:0] tx [NUM_TPL];
		logic signed [15:0] ty [NUM_TPL];
		logic [6:0] perm [NUM_TPL];
		gn2_rsp_t pending[$];
		int errors;

		function new();
			grid_c = 64;
			grid_r = 64;
			errors = 0;
			for (int i = 0; i < NUM_TPL; i++) begin
				tx[i] = 0;
				ty[i] = 0;
				perm[i] = 7'(i);
			end
		endfunction

		function longint rshift_round(longint v, int sh);
			longint w;
			w = v + (longint'(1) <<< (sh - 1));
			return w >>> sh;
		endfunction

		function longint fade_curve(longint f);
			longint t2, t3, p;
			t2 = (f * f) >> FRAC_BITS;
			t3 = (t2 * f) >> FRAC_BITS;
			p = (longint'(10) << FRAC_BITS) + 6 * t2 - 15 * f;
			if (p < 0)
				p = 0;
			return (t3 * p) >> FRAC_BITS;
		endfunction

		function longint corner(longint row, longint col, longint dx, longint dy);
			int g;
			longint a;
			a = perm[row % NUM_TPL];
			g = perm[(a + col) % NUM_TPL];
			return rshift_round(longint'(tx[g]) * dx + longint'(ty[g]) * dy, FRAC_BITS - 1);
		endfunction

		function longint lerp(longint a, longint b, longint s);
			return a + rshift_round((b - a) * s, FRAC_BITS);
		endfunction

		function void note_beat(gn2_req_t r);
			longint cols, rows, px, py, c0, r0, fx, fy, one, su, sv;
			longint n0, n1, n2, n3, val, sat, nrm;
			gn2_rsp_t e;
			if (r.func == FN_TPL) begin
				tx[r.table_index] = r.grad_x;
				ty[r.table_index] = r.grad_y;
				return;
			end
			if (r.func == FN_PERM) begin
				perm[r.table_index] = r.perm_entry;
				return;
			end
			if (r.func != FN_SAMPLE)
				return;
			cols = grid_c < MIN_GRID ? MIN_GRID : grid_c > MAX_GRID ? MAX_GRID : grid_c;
			rows = grid_r < MIN_GRID ? MIN_GRID : grid_r > MAX_GRID ? MAX_GRID : grid_r;
			one = longint'(1) << FRAC_BITS;
			px = longint'(r.coord_u) * cols;
			py = longint'(r.coord_v) * rows;
			c0 = px >> FRAC_BITS;
			r0 = py >> FRAC_BITS;
			fx = px & (one - 1);
			fy = py & (one - 1);
			su = fade_curve(fx);
			sv = fade_curve(fy);
			n0 = corner(r0 % rows, c0 % cols, fx, fy);
			n1 = corner(r0 % rows, (c0 + 1) % cols, fx - one, fy);
			n2 = corner((r0 + 1) % rows, c0 % cols, fx, fy - one);
			n3 = corner((r0 + 1) % rows, (c0 + 1) % cols, fx - one, fy - one);
			val = lerp(lerp(n0, n1, su), lerp(n2, n3, su), sv);
			sat = val > 32767 ? 32767 : val < -32768 ? -32768 : val;
			nrm = val + 32768;
			nrm = nrm > 65535 ? 65535 : nrm < 0 ? 0 : nrm;
			e.noise_value = 16'(sat);
			e.noise_norm = 16'(nrm);
			pending.push_back(e);
		endfunction

		function void check_beat(gn2_rsp_t got);
			gn2_rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat value=%0d norm=%0d", got.noise_value,
						got.noise_norm);
				return;
			end
			e = pending.pop_front();
			if (got.noise_value !== e.noise_value || got.noise_norm !== e.noise_norm) begin
				errors++;
				if (errors <= 10)
					$display("mismatch value exp %0d got %0d, norm exp %0d got %0d",
						e.noise_value, got.noise_value, e.noise_norm, got.noise_norm);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic req_valid = 0, rsp_ready = 0, rsp_valid, req_ready;
	gn2_req_t req = '0;
	gn2_rsp_t rsp;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	int send_idle, recv_idle;
	longint cycles = 0;
	noise_scoreboard sb = new();

	gradient_noise_2d_sampler_core dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_beat(rsp);
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send(gn2_req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_beat(r);
	endtask

	task automatic reg_write(logic [2:0] a, int unsigned v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (a == REG_COLS)
			sb.grid_c = v & 11'h7ff;
		else
			sb.grid_r = v & 11'h7ff;
	endtask

	task automatic drain();
		int n;
		n = 0;
		req_valid <= 0;
		while (sb.pending.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
	endtask

	function automatic gn2_req_t sample(int u, int v);
		gn2_req_t r;
		r = '0;
		r.func = FN_SAMPLE;
		r.coord_u = 17'(u);
		r.coord_v = 17'(v);
		r.table_index = 7'($urandom);
		r.perm_entry = 7'($urandom);
		return r;
	endfunction

	function automatic gn2_req_t tpl(int i, int gx, int gy);
		gn2_req_t r;
		r = sample($urandom, $urandom);
		r.func = FN_TPL;
		r.table_index = 7'(i);
		r.grad_x = 16'(gx);
		r.grad_y = 16'(gy);
		return r;
	endfunction

	function automatic gn2_req_t rnd_item();
		gn2_req_t r;
		int k;
		k = $urandom_range(99);
		if (k < 8) begin
			r = tpl($urandom_range(127), $urandom_range(32768) - 16384,
				$urandom_range(32768) - 16384);
		end else if (k < 14) begin
			r = sample(0, 0);
			r.func = FN_PERM;
			r.table_index = 7'($urandom);
			r.perm_entry = 7'($urandom);
			r.grad_x = 16'($urandom);
		end else if (k < 17) begin
			r = sample($urandom, $urandom);
			r.func = 2'd3;
		end else if (k < 22) begin
			r = sample($urandom_range(131071), $urandom_range(131071));
			r.grad_x = 16'($urandom);
			r.grad_y = 16'($urandom);
		end else begin
			r = sample($urandom_range(65536), $urandom_range(65536));
		end
		return r;
	endfunction

	initial begin
		int grids [6][2];
		gn2_req_t r;
		grids = '{'{64, 64}, '{2, 2}, '{1024, 1024}, '{0, 2047}, '{3, 1000}, '{17, 5}};
		send_idle = 0;
		recv_idle = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// every template entry must be written before any sample reads it
		for (int i = 0; i < NUM_TPL; i++) begin
			case (i)
				0: send(tpl(i, -16384, 16384));
				1: send(tpl(i, 16384, -16384));
				2: send(tpl(i, -1, 32767));
				default: send(tpl(i, $urandom_range(32768) - 16384,
					$urandom_range(32768) - 16384));
			endcase
		end
		send(sample(0, 0));
		send(sample(65536, 65536));
		send(sample(131071, 0));
		send(sample(32768, 65535));
		r = sample(0, 0);
		r.func = FN_PERM;
		r.table_index = 7'd127;
		r.perm_entry = 7'd127;
		send(r);
		r.table_index = 7'd5;
		r.perm_entry = 7'd0;
		send(r);
		r = sample(1234, 4321);
		r.func = 2'd3;
		send(r);
		r = tpl(0, 16384, 16384);
		send(r);
		send(sample(1, 65535));
		for (int g = 0; g < 6; g++) begin
			drain();
			reg_write(REG_COLS, grids[g][0]);
			reg_write(REG_ROWS, grids[g][1]);
			for (int n = 0; n < 235; n++) begin
				if (n == 0) begin
					send_idle = 25;
					recv_idle = 71;
				end else if (n == 80) begin
					send_idle = 71;
					recv_idle = 25;
				end else if (n == 160) begin
					send_idle = 0;
					recv_idle = 0;
				end
				send(rnd_item());
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
